// ===== design/tracker_channel_volume_pan_effects_core_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef TRACKER_CHANNEL_VOLUME_PAN_EFFECTS_CORE_MACROS_SVH
`define TRACKER_CHANNEL_VOLUME_PAN_EFFECTS_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define TCVP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define TCVP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcvp_pkg.sv =====
package tcvp_pkg;

    // Effect commands
    localparam logic [3:0] CMD_NONE         = 4'd0;
    localparam logic [3:0] CMD_SET_VOL      = 4'd1;
    localparam logic [3:0] CMD_VOL_SLIDE    = 4'd2;
    localparam logic [3:0] CMD_TREMOR       = 4'd3;
    localparam logic [3:0] CMD_SET_CHVOL    = 4'd4;
    localparam logic [3:0] CMD_CHVOL_SLIDE  = 4'd5;
    localparam logic [3:0] CMD_PAN_SLIDE    = 4'd6;
    localparam logic [3:0] CMD_RETRIG       = 4'd7;
    localparam logic [3:0] CMD_SET_GVOL     = 4'd8;
    localparam logic [3:0] CMD_GVOL_SLIDE   = 4'd9;
    localparam logic [3:0] CMD_SET_PAN      = 4'd10;
    localparam logic [3:0] CMD_VC_FINE_UP   = 4'd11;
    localparam logic [3:0] CMD_VC_FINE_DOWN = 4'd12;
    localparam logic [3:0] CMD_VC_UP        = 4'd13;
    localparam logic [3:0] CMD_VC_DOWN      = 4'd14;
    localparam logic [3:0] CMD_SURROUND     = 4'd15;

    // Slide speed memory slots
    localparam int         MEM_COUNT = 5;
    localparam logic [2:0] MEM_D     = 3'd0;
    localparam logic [2:0] MEM_N     = 3'd1;
    localparam logic [2:0] MEM_P     = 3'd2;
    localparam logic [2:0] MEM_W     = 3'd3;
    localparam logic [2:0] MEM_VC    = 3'd4;

    localparam logic [7:0] VOL_TOP  = 8'd64;
    localparam logic [7:0] GVOL_TOP = 8'd128;

    localparam int OUT_W = 40;

    // Divider sizes
    localparam int DIV_W   = 8;
    localparam int DVS_W   = 6;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_WB
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== design/tracker_channel_volume_pan_effects_core.sv =====
// Per-channel tick processor for tracker volume, pan and slide effects. Each item is one
// tick: s_tdata carries the parameter byte, s_tuser the command and first-tick flag. Most
// ticks pass through ST_CALC and ST_WB; a tremor tick with a nonzero period, or a retrigger
// tick that fires with the two-thirds volume change, also waits in ST_DIV on the shared
// 8-step restoring divider (tremor period modulo, divide by three). The block takes one item
// at a time; a finished result sits in the output register and the next tick is accepted
// while it waits. old_effects is to be written through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block itself does not enforce this.
module tracker_channel_volume_pan_effects_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,   // old_effects
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,       // param[7:0]
    input  logic [4:0]                 s_tuser,       // cmd[3:0], first_tick[4]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // volume[6:0], channel_volume[13:7], pan[20:14], global_volume[28:21],
    // gated_volume[35:29], gate_active[36], retrigger[37], surround[38], zero[39]
    output logic [tcvp_pkg::OUT_W-1:0] m_tdata
);

    localparam logic [3:0] NIB_FULL = 4'hF;
    localparam logic [3:0] NIB_ZERO = 4'h0;
    localparam logic [2:0] RT_NONE  = 3'd0;
    localparam logic [2:0] RT_SCALE = 3'd6;
    localparam logic [2:0] RT_HALVE = 3'd7;
    localparam logic [5:0] DIV_BY_3 = 6'd3;

    tcvp_pkg::state_t state_reg, state_next;

    logic [3:0] cmd_reg;
    logic [7:0] param_reg;
    logic       first_reg;
    logic       old_effects_reg;

    logic [6:0] note_vol_reg, chan_vol_reg, pan_reg;
    logic [7:0] song_vol_reg;
    logic       surround_reg;
    logic [7:0] slide_mem_reg [tcvp_pkg::MEM_COUNT];
    logic [7:0] tremor_mem_reg, retrig_mem_reg, tremor_cnt_reg, retrig_cnt_reg;

    logic                       m_valid_reg;
    logic [tcvp_pkg::OUT_W-1:0] m_data_reg;

    logic [6:0] note_vol_next, chan_vol_next, pan_next, gated_next;
    logic [7:0] song_vol_next, tremor_cnt_next, retrig_cnt_next;
    logic       surround_next, gate_next, kick_next;

    tcvp_pkg::div_req_t div_req;
    tcvp_pkg::div_rsp_t div_rsp;

    logic       s_accept, out_free, commit;
    logic [4:0] trem_on, trem_off;
    logic [5:0] trem_period;
    logic       retrig_fire;
    logic       need_div;

    function automatic logic [7:0] sat_up_f(input logic [7:0] v, input logic [7:0] d,
                                            input logic [7:0] top);
        logic [8:0] s;
        s = {1'b0, v} + {1'b0, d};
        return (s < {1'b0, top}) ? s[7:0] : top;
    endfunction

    function automatic logic [7:0] sat_down_f(input logic [7:0] v, input logic [7:0] d);
        return (v > d) ? v - d : 8'd0;
    endfunction

    // Fine slides on the first tick (other nibble full), normal slides later (other nibble zero).
    function automatic logic [7:0] slide_f(input logic [7:0] v, input logic [7:0] spd,
                                           input logic first, input logic [7:0] top);
        logic [3:0] hi, lo;
        logic [7:0] r;
        hi = spd[7:4];
        lo = spd[3:0];
        r  = v;
        if (first) begin
            if (hi == NIB_FULL) r = sat_down_f(v, {4'h0, lo});
            else if (lo == NIB_FULL) r = sat_up_f(v, {4'h0, hi}, top);
        end else begin
            if (hi == NIB_ZERO) r = sat_down_f(v, {4'h0, lo});
            else if (lo == NIB_ZERO) r = sat_up_f(v, {4'h0, hi}, top);
        end
        return r;
    endfunction

    // Retrigger volume change; q3 is (2*v)/3 from the divider.
    function automatic logic [6:0] retrig_vol_f(input logic [6:0] v, input logic [3:0] typ,
                                                input logic [7:0] q3);
        logic [7:0] w, d, r;
        logic [8:0] t;
        w = {1'b0, v};
        d = 8'd1 << (typ[2:0] - 3'd1);
        r = w;
        t = {1'b0, w};
        if (typ[2:0] == RT_NONE) begin
            r = w;
        end else if (typ[2:0] == RT_SCALE) begin
            t = ({1'b0, w} + {w, 1'b0}) >> 1;
            r = typ[3] ? ((t > {1'b0, tcvp_pkg::VOL_TOP}) ? tcvp_pkg::VOL_TOP : t[7:0]) : q3;
        end else if (typ[2:0] == RT_HALVE) begin
            t = {w, 1'b0};
            r = typ[3] ? ((t > {1'b0, tcvp_pkg::VOL_TOP}) ? tcvp_pkg::VOL_TOP : t[7:0])
                       : {1'b0, w[7:1]};
        end else begin
            r = typ[3] ? sat_up_f(w, d, tcvp_pkg::VOL_TOP) : sat_down_f(w, d);
        end
        return r[6:0];
    endfunction

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = (state_reg == tcvp_pkg::ST_WB) && out_free;

    always_comb begin
        trem_on     = {1'b0, tremor_mem_reg[7:4]} + {4'd0, old_effects_reg};
        trem_off    = {1'b0, tremor_mem_reg[3:0]} + {4'd0, old_effects_reg};
        trem_period = {1'b0, trem_on} + {1'b0, trem_off};
        retrig_fire = retrig_cnt_reg >= {4'd0, retrig_mem_reg[3:0]};
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= tcvp_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next       = state_reg;
        need_div         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = tremor_cnt_reg;
        div_req.divisor  = trem_period;
        s_tready         = 1'b0;
        case (state_reg)
            tcvp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = tcvp_pkg::ST_CALC;
            end
            tcvp_pkg::ST_CALC: begin
                if (cmd_reg == tcvp_pkg::CMD_TREMOR) begin
                    need_div = trem_period != 6'd0;
                end else if (cmd_reg == tcvp_pkg::CMD_RETRIG) begin
                    need_div         = retrig_fire && (retrig_mem_reg[7:4] == {1'b0, RT_SCALE});
                    div_req.dividend = {note_vol_reg, 1'b0};
                    div_req.divisor  = DIV_BY_3;
                end
                div_req.start = need_div;
                state_next    = need_div ? tcvp_pkg::ST_DIV : tcvp_pkg::ST_WB;
            end
            tcvp_pkg::ST_DIV: begin
                if (div_rsp.done) state_next = tcvp_pkg::ST_WB;
            end
            tcvp_pkg::ST_WB: begin
                if (out_free) state_next = tcvp_pkg::ST_IDLE;
            end
            default: state_next = tcvp_pkg::ST_IDLE;
        endcase
    end

    tcvp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Tick result
    always_comb begin
        logic [7:0] t8;
        logic [7:0] spd;
        logic [7:0] tc8;
        note_vol_next   = note_vol_reg;
        chan_vol_next   = chan_vol_reg;
        pan_next        = pan_reg;
        song_vol_next   = song_vol_reg;
        surround_next   = surround_reg;
        tremor_cnt_next = tremor_cnt_reg;
        retrig_cnt_next = retrig_cnt_reg;
        gate_next       = 1'b0;
        kick_next       = 1'b0;
        gated_next      = 7'd0;
        t8              = 8'd0;
        spd             = 8'd0;
        tc8             = 8'd0;
        case (cmd_reg)
            tcvp_pkg::CMD_NONE: ;
            tcvp_pkg::CMD_SET_VOL: begin
                if (first_reg && param_reg <= tcvp_pkg::VOL_TOP) note_vol_next = param_reg[6:0];
            end
            tcvp_pkg::CMD_VOL_SLIDE: begin
                spd = slide_mem_reg[tcvp_pkg::MEM_D];
                // Full-speed fine forms on the first tick
                if (first_reg && spd[7:4] == NIB_FULL && spd[3:0] == NIB_ZERO)
                    t8 = sat_up_f({1'b0, note_vol_reg}, 8'd15, tcvp_pkg::VOL_TOP);
                else if (first_reg && spd[3:0] == NIB_FULL && spd[7:4] == NIB_ZERO)
                    t8 = sat_down_f({1'b0, note_vol_reg}, 8'd15);
                else
                    t8 = slide_f({1'b0, note_vol_reg}, spd, first_reg, tcvp_pkg::VOL_TOP);
                note_vol_next = t8[6:0];
            end
            tcvp_pkg::CMD_TREMOR: begin
                tc8             = (trem_period != 6'd0) ? {2'b0, div_rsp.remainder} : 8'd0;
                gated_next      = (tc8 < {3'b0, trem_on}) ? note_vol_reg : 7'd0;
                tremor_cnt_next = tc8 + 8'd1;
                gate_next       = 1'b1;
            end
            tcvp_pkg::CMD_SET_CHVOL: begin
                if (first_reg && param_reg <= tcvp_pkg::VOL_TOP) chan_vol_next = param_reg[6:0];
            end
            tcvp_pkg::CMD_CHVOL_SLIDE: begin
                t8 = slide_f({1'b0, chan_vol_reg}, slide_mem_reg[tcvp_pkg::MEM_N], first_reg,
                             tcvp_pkg::VOL_TOP);
                chan_vol_next = t8[6:0];
            end
            tcvp_pkg::CMD_PAN_SLIDE: begin
                // low nibble moves right, high nibble moves left
                spd = slide_mem_reg[tcvp_pkg::MEM_P];
                t8  = {1'b0, pan_reg};
                if (first_reg) begin
                    if (spd[7:4] == NIB_FULL)
                        t8 = sat_up_f({1'b0, pan_reg}, {4'h0, spd[3:0]}, tcvp_pkg::VOL_TOP);
                    else if (spd[3:0] == NIB_FULL)
                        t8 = sat_down_f({1'b0, pan_reg}, {4'h0, spd[7:4]});
                end else begin
                    if (spd[7:4] == NIB_ZERO)
                        t8 = sat_up_f({1'b0, pan_reg}, {4'h0, spd[3:0]}, tcvp_pkg::VOL_TOP);
                    else if (spd[3:0] == NIB_ZERO)
                        t8 = sat_down_f({1'b0, pan_reg}, {4'h0, spd[7:4]});
                end
                pan_next = t8[6:0];
            end
            tcvp_pkg::CMD_RETRIG: begin
                if (retrig_fire) begin
                    note_vol_next   = retrig_vol_f(note_vol_reg, retrig_mem_reg[7:4],
                                                   div_rsp.quotient);
                    retrig_cnt_next = 8'd1;
                    kick_next       = 1'b1;
                end else begin
                    retrig_cnt_next = retrig_cnt_reg + 8'd1;
                end
            end
            tcvp_pkg::CMD_SET_GVOL: begin
                if (first_reg && param_reg <= tcvp_pkg::GVOL_TOP) song_vol_next = param_reg;
            end
            tcvp_pkg::CMD_GVOL_SLIDE: begin
                song_vol_next = slide_f(song_vol_reg, slide_mem_reg[tcvp_pkg::MEM_W], first_reg,
                                        tcvp_pkg::GVOL_TOP);
            end
            tcvp_pkg::CMD_SET_PAN: begin
                if (first_reg) begin
                    t8            = 8'(({1'b0, param_reg} + 9'd2) >> 2);
                    pan_next      = t8[6:0];
                    surround_next = 1'b0;
                end
            end
            tcvp_pkg::CMD_VC_FINE_UP, tcvp_pkg::CMD_VC_UP: begin
                if (first_reg == (cmd_reg == tcvp_pkg::CMD_VC_FINE_UP)) begin
                    t8 = sat_up_f({1'b0, note_vol_reg}, slide_mem_reg[tcvp_pkg::MEM_VC],
                                  tcvp_pkg::VOL_TOP);
                    note_vol_next = t8[6:0];
                end
            end
            tcvp_pkg::CMD_VC_FINE_DOWN, tcvp_pkg::CMD_VC_DOWN: begin
                if (first_reg == (cmd_reg == tcvp_pkg::CMD_VC_FINE_DOWN)) begin
                    t8 = sat_down_f({1'b0, note_vol_reg}, slide_mem_reg[tcvp_pkg::MEM_VC]);
                    note_vol_next = t8[6:0];
                end
            end
            tcvp_pkg::CMD_SURROUND: surround_next = 1'b1;
            default: ;
        endcase
        if (!gate_next) gated_next = note_vol_next;
    end

    // Item capture and speed memories (updated before use, on accept)
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_tuser[3:0];
            param_reg <= s_tdata;
            first_reg <= s_tuser[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_effects_reg <= 1'b0;
            note_vol_reg    <= 7'd0;
            chan_vol_reg    <= tcvp_pkg::VOL_TOP[6:0];
            pan_reg         <= 7'd32;
            song_vol_reg    <= tcvp_pkg::GVOL_TOP;
            surround_reg    <= 1'b0;
            for (int i = 0; i < tcvp_pkg::MEM_COUNT; i++) slide_mem_reg[i] <= 8'd0;
            tremor_mem_reg  <= 8'd0;
            retrig_mem_reg  <= 8'd0;
            tremor_cnt_reg  <= 8'd0;
            retrig_cnt_reg  <= 8'd0;
        end else begin
            if (cfg_wr_en) old_effects_reg <= cfg_wr_data;
            if (s_accept && s_tuser[4] && s_tdata != 8'd0) begin
                case (s_tuser[3:0])
                    tcvp_pkg::CMD_VOL_SLIDE:   slide_mem_reg[tcvp_pkg::MEM_D] <= s_tdata;
                    tcvp_pkg::CMD_CHVOL_SLIDE: slide_mem_reg[tcvp_pkg::MEM_N] <= s_tdata;
                    tcvp_pkg::CMD_PAN_SLIDE:   slide_mem_reg[tcvp_pkg::MEM_P] <= s_tdata;
                    tcvp_pkg::CMD_GVOL_SLIDE:  slide_mem_reg[tcvp_pkg::MEM_W] <= s_tdata;
                    tcvp_pkg::CMD_VC_FINE_UP, tcvp_pkg::CMD_VC_FINE_DOWN,
                    tcvp_pkg::CMD_VC_UP, tcvp_pkg::CMD_VC_DOWN:
                        slide_mem_reg[tcvp_pkg::MEM_VC] <= s_tdata;
                    tcvp_pkg::CMD_TREMOR:      tremor_mem_reg <= s_tdata;
                    tcvp_pkg::CMD_RETRIG:      retrig_mem_reg <= s_tdata;
                    default: ;
                endcase
            end
            if (commit) begin
                note_vol_reg   <= note_vol_next;
                chan_vol_reg   <= chan_vol_next;
                pan_reg        <= pan_next;
                song_vol_reg   <= song_vol_next;
                surround_reg   <= surround_next;
                tremor_cnt_reg <= tremor_cnt_next;
                retrig_cnt_reg <= retrig_cnt_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= {1'b0, surround_next, kick_next, gate_next, gated_next,
                           song_vol_next, pan_next, chan_vol_next, note_vol_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/tcvp_div.sv =====
module tcvp_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcvp_pkg::div_req_t req,
    output tcvp_pkg::div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [tcvp_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [tcvp_pkg::DIV_W-1:0]     quo_reg;
    logic [tcvp_pkg::DVS_W-1:0]     rem_reg;
    logic [tcvp_pkg::DVS_W-1:0]     dvs_reg;

    logic [tcvp_pkg::DVS_W:0]       trial;
    logic                           fits;
    logic [tcvp_pkg::DVS_W:0]       diff;

    // One restoring step per cycle, dividend shifted in MSB first.
    always_comb begin
        trial = {rem_reg, quo_reg[tcvp_pkg::DIV_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tcvp_pkg::DIV_CNT_W'(tcvp_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[tcvp_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? diff[tcvp_pkg::DVS_W-1:0] : trial[tcvp_pkg::DVS_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== design/tcvp_checker.sv =====
`include "tracker_channel_volume_pan_effects_core_macros.svh"

module tcvp_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tcvp_pkg::OUT_W-1:0] m_tdata
);

    // one tick at a time: busy right after an accept
    `TCVP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")

    `TCVP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed under stall")

    `TCVP_ASSERT_SAME(a_out_range, m_tvalid, (m_tdata[6:0] <= 7'd64) && (m_tdata[13:7] <= 7'd64) && (m_tdata[20:14] <= 7'd64) && (m_tdata[28:21] <= 8'd128), "level out of range")

    // without tremor the gated level follows the note volume
    `TCVP_ASSERT_SAME(a_gate_pass, m_tvalid && !m_tdata[36], m_tdata[35:29] == m_tdata[6:0], "gated volume mismatch")

endmodule

bind tracker_channel_volume_pan_effects_core tcvp_checker u_tcvp_checker (.*);
